>>> rtl/core/rph_pkg.sv
// ----------------------------------------------------------------------------
// rph_pkg
// Shared sizes, command codes and register indexes for the ROI pixel
// histogram core.
// ----------------------------------------------------------------------------
package rph_pkg;

    // Histogram storage
    localparam int MAX_BINS      = 1024;
    localparam int BIN_ADDR_BITS = $clog2(MAX_BINS);
    localparam int COUNT_BITS    = 32;

    // Field widths
    localparam int COORD_BITS     = 9;
    localparam int VALUE_BITS     = 16;
    localparam int BIN_COUNT_BITS = 11;
    localparam int STEP_BITS      = $clog2(VALUE_BITS);

    // Stream word widths, rounded up to whole bytes
    localparam int IN_FIELD_BITS  = VALUE_BITS + 2 * COORD_BITS + BIN_ADDR_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = COUNT_BITS + BIN_ADDR_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int CMD_BITS       = 2;
    localparam int IN_TUSER_BITS  = 8;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Command carried in tuser
    typedef enum logic [CMD_BITS-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BIN_LOW    = 3'd0,
        REG_BIN_WIDTH  = 3'd1,
        REG_BIN_COUNT  = 3'd2,
        REG_ROI_X_LOW  = 3'd3,
        REG_ROI_X_HIGH = 3'd4,
        REG_ROI_Y_LOW  = 3'd5,
        REG_ROI_Y_HIGH = 3'd6
    } t_cfg_reg;

endpackage

>>> rtl/core/roi_pixel_histogram_core.sv
// ----------------------------------------------------------------------------
// roi_pixel_histogram_core
// Saturating histogram of pixel values inside a rectangular region of
// interest, held in a single-port bin memory with clear and read commands.
// ----------------------------------------------------------------------------
// The block handles one word at a time. A sample inside the region whose
// value lies above bin_low passes a one-bit-per-cycle restoring divider that
// finds the bin, a read of the bin memory and a write back of the
// incremented count; the write is skipped when its bin lies beyond the bins
// in use. A sample at or below bin_low goes to bin zero through the read and
// the write back. A sample outside the region, a sample above bin_low with a
// zero bin width and a word of an unknown command are taken and dropped; a
// read waits until the output register is free. A clear, and reset itself,
// start a clearing pass over all 1024 bins, one bin per cycle, during which
// no word is accepted; configuration writes are taken at all times. A read
// result waits in an output register, so the next word is accepted while it
// is still pending.
module roi_pixel_histogram_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rph_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [rph_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // Input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata from bit 0: pixel_value[15:0], pixel_col[24:16],
    // pixel_row[33:25], read_index[43:34], zero fill
    input  logic [rph_pkg::IN_TDATA_BITS-1:0]   i_s_axis_tdata,
    // tuser from bit 0: cmd[1:0], zero fill
    input  logic [rph_pkg::IN_TUSER_BITS-1:0]   i_s_axis_tuser,
    // Output stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata from bit 0: bin_total[31:0], bin_number[41:32], zero fill
    output logic [rph_pkg::OUT_TDATA_BITS-1:0]  o_m_axis_tdata
);
    import rph_pkg::*;

    localparam int VAL_LSB = 0;
    localparam int COL_LSB = VAL_LSB + VALUE_BITS;
    localparam int ROW_LSB = COL_LSB + COORD_BITS;
    localparam int IDX_LSB = ROW_LSB + COORD_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_BIN,
        ST_UPD,
        ST_READ
    } t_state;

    // Configuration registers
    logic signed [VALUE_BITS-1:0]     r_bin_low;
    logic        [VALUE_BITS-1:0]     r_bin_width;
    logic        [BIN_COUNT_BITS-1:0] r_bin_count;
    logic        [COORD_BITS-1:0]     r_roi_x_low;
    logic        [COORD_BITS-1:0]     r_roi_x_high;
    logic        [COORD_BITS-1:0]     r_roi_y_low;
    logic        [COORD_BITS-1:0]     r_roi_y_high;

    // Control and datapath registers
    t_state                     r_state;
    logic [BIN_ADDR_BITS-1:0]   r_clr_addr;
    logic [BIN_ADDR_BITS-1:0]   r_bin;
    logic [VALUE_BITS-1:0]      r_quo;
    logic [VALUE_BITS-1:0]      r_rem;
    logic [STEP_BITS-1:0]       r_step;
    logic                       r_out_valid;
    logic [COUNT_BITS-1:0]      r_out_total;
    logic [BIN_ADDR_BITS-1:0]   r_out_number;

    // Bin memory and its registered read data
    logic [COUNT_BITS-1:0]      bin_mem [MAX_BINS];
    logic [COUNT_BITS-1:0]      r_rd_data;

    // Input word decoding
    logic                       s_fire;
    t_cmd                       in_cmd;
    logic signed [VALUE_BITS-1:0] in_value;
    logic [COORD_BITS-1:0]      in_col;
    logic [COORD_BITS-1:0]      in_row;
    logic [BIN_ADDR_BITS-1:0]   in_index;
    logic                       in_roi;
    logic [VALUE_BITS:0]        in_diff;

    // Bin selection and memory control
    logic [BIN_COUNT_BITS-1:0]  used;
    logic [VALUE_BITS:0]        bin_k;
    logic                       bin_ok;
    logic [VALUE_BITS:0]        div_trial;
    logic [VALUE_BITS:0]        div_part;
    logic                       mem_we;
    logic [BIN_ADDR_BITS-1:0]   mem_waddr;
    logic [COUNT_BITS-1:0]      mem_wdata;
    logic                       mem_re;
    logic [BIN_ADDR_BITS-1:0]   mem_raddr;
    logic                       out_free;

    assign in_cmd   = t_cmd'(i_s_axis_tuser[CMD_BITS-1:0]);
    assign in_value = i_s_axis_tdata[VAL_LSB +: VALUE_BITS];
    assign in_col   = i_s_axis_tdata[COL_LSB +: COORD_BITS];
    assign in_row   = i_s_axis_tdata[ROW_LSB +: COORD_BITS];
    assign in_index = i_s_axis_tdata[IDX_LSB +: BIN_ADDR_BITS];

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // Region test and distance above the first edge (positive when used).
    assign in_roi = (in_col >= r_roi_x_low) && (in_col <= r_roi_x_high) &&
                    (in_row >= r_roi_y_low) && (in_row <= r_roi_y_high);
    assign in_diff = {in_value[VALUE_BITS-1], in_value} -
                     {r_bin_low[VALUE_BITS-1], r_bin_low};

    // Number of bins in use: zero acts as one, excess acts as the maximum.
    always_comb begin
        if (r_bin_count == '0) begin
            used = BIN_COUNT_BITS'(1);
        end else if (r_bin_count > BIN_COUNT_BITS'(MAX_BINS)) begin
            used = BIN_COUNT_BITS'(MAX_BINS);
        end else begin
            used = r_bin_count;
        end
    end

    // Ceiling of the quotient, and whether that bin is in use.
    assign bin_k  = {1'b0, r_quo} + (VALUE_BITS + 1)'(r_rem != '0);
    assign bin_ok = bin_k < (VALUE_BITS + 1)'(used);

    // One restoring division step: shift in the next dividend bit and try
    // to subtract the divisor.
    assign div_part  = {r_rem, r_quo[VALUE_BITS-1]};
    assign div_trial = div_part - {1'b0, r_bin_width};

    // Memory port control: the clearing pass and the count update write,
    // a read word and a bin lookup read.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_bin;
        mem_wdata = '0;
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
        end else if (r_state == ST_UPD) begin
            mem_we    = 1'b1;
            mem_wdata = (r_rd_data == '1) ? r_rd_data : r_rd_data + COUNT_BITS'(1);
        end
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = in_index;
        if (s_fire && (in_cmd == CMD_READ)) begin
            mem_re = 1'b1;
        end else if ((r_state == ST_BIN) && bin_ok) begin
            mem_re    = 1'b1;
            mem_raddr = bin_k[BIN_ADDR_BITS-1:0];
        end
    end

    // Bin memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            bin_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= bin_mem[mem_raddr];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_low    <= '0;
            r_bin_width  <= VALUE_BITS'(1);
            r_bin_count  <= BIN_COUNT_BITS'(MAX_BINS);
            r_roi_x_low  <= '0;
            r_roi_x_high <= '1;
            r_roi_y_low  <= '0;
            r_roi_y_high <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_BIN_LOW:    r_bin_low    <= i_cfg_data[VALUE_BITS-1:0];
                REG_BIN_WIDTH:  r_bin_width  <= i_cfg_data[VALUE_BITS-1:0];
                REG_BIN_COUNT:  r_bin_count  <= i_cfg_data[BIN_COUNT_BITS-1:0];
                REG_ROI_X_LOW:  r_roi_x_low  <= i_cfg_data[COORD_BITS-1:0];
                REG_ROI_X_HIGH: r_roi_x_high <= i_cfg_data[COORD_BITS-1:0];
                REG_ROI_Y_LOW:  r_roi_y_low  <= i_cfg_data[COORD_BITS-1:0];
                REG_ROI_Y_HIGH: r_roi_y_high <= i_cfg_data[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer with the divider and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + BIN_ADDR_BITS'(1);
                    if (r_clr_addr == BIN_ADDR_BITS'(MAX_BINS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        r_bin <= in_index;
                        unique case (in_cmd)
                            CMD_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state    <= ST_CLEAR;
                            end
                            CMD_SAMPLE: begin
                                if (in_roi) begin
                                    if (in_value <= r_bin_low) begin
                                        // At or below the first edge: bin zero.
                                        r_quo   <= '0;
                                        r_rem   <= '0;
                                        r_state <= ST_BIN;
                                    end else if (r_bin_width != '0) begin
                                        r_quo   <= in_diff[VALUE_BITS-1:0];
                                        r_rem   <= '0;
                                        r_step  <= STEP_BITS'(VALUE_BITS - 1);
                                        r_state <= ST_DIV;
                                    end
                                end
                            end
                            CMD_READ: begin
                                r_state <= ST_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DIV: begin
                    if (!div_trial[VALUE_BITS]) begin
                        r_rem <= div_trial[VALUE_BITS-1:0];
                        r_quo <= {r_quo[VALUE_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= div_part[VALUE_BITS-1:0];
                        r_quo <= {r_quo[VALUE_BITS-2:0], 1'b0};
                    end
                    r_step <= r_step - STEP_BITS'(1);
                    if (r_step == '0) begin
                        r_state <= ST_BIN;
                    end
                end
                ST_BIN: begin
                    r_bin   <= bin_k[BIN_ADDR_BITS-1:0];
                    r_state <= bin_ok ? ST_UPD : ST_IDLE;
                end
                ST_UPD: begin
                    r_state <= ST_IDLE;
                end
                ST_READ: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_total  <= r_rd_data;
                        r_out_number <= r_bin;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_BITS - OUT_FIELD_BITS)'(0),
                              r_out_number, r_out_total};

    // A result appears only when a read word completes.
    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == ST_READ))
        else $error("result shown without a read word");

    // A count update only ever targets a bin in use.
    a_upd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> ((BIN_COUNT_BITS)'(r_bin) < used))
        else $error("count update outside the bins in use");

    // A clear word starts the pass from the first bin.
    a_clear_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && (in_cmd == CMD_CLEAR)) |=> ((r_state == ST_CLEAR) && (r_clr_addr == '0)))
        else $error("clear word did not start the clearing pass");

    // A read result is not overwritten while it waits.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(r_out_total)))
        else $error("pending result lost");

endmodule
